[hw/rtl/parametric_path_point_generator_top_defines.svh]
// Assertion macros for the path point generator
`ifndef PARAMETRIC_PATH_POINT_GENERATOR_TOP_DEFINES_SVH
`define PARAMETRIC_PATH_POINT_GENERATOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define PPG_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define PPG_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ppg_pkg.sv]
// Shared types and constants of the path point generator
`default_nettype none

package ppg_pkg;

  localparam int unsigned IDX_W     = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned RADIUS_W  = 31;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned TRIG_W    = 31;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned SUM_W     = 33;
  localparam int unsigned OSUM_W    = COORD_W + 2;
  localparam int unsigned Q_SHIFT   = 30;
  localparam logic [TRIG_W-1:0] Q30_ONE = TRIG_W'(64'd1 << Q_SHIFT);
  localparam logic [63:0] HALF_PI_Q32 = 64'd6746518852;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATH_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTS_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MODE   = 3'd4;

  localparam int unsigned SER_STEPS  = 9;
  localparam int unsigned SER_STEP_W = 4;
  localparam int unsigned SER_REM_W  = 10;
  localparam logic [SER_STEP_W-1:0] SER_LAST = SER_STEP_W'(SER_STEPS - 1);

  // divisors (2n)(2n+1) of the sine series and their truncated 2^32 reciprocals
  localparam logic [SER_REM_W-1:0] SER_DIV [SER_STEPS] = '{
    10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156, 10'd210, 10'd272, 10'd342
  };
  localparam logic [31:0] SER_RCP [SER_STEPS] = '{
    32'(64'h1_0000_0000 / 64'd6),   32'(64'h1_0000_0000 / 64'd20),
    32'(64'h1_0000_0000 / 64'd42),  32'(64'h1_0000_0000 / 64'd72),
    32'(64'h1_0000_0000 / 64'd110), 32'(64'h1_0000_0000 / 64'd156),
    32'(64'h1_0000_0000 / 64'd210), 32'(64'h1_0000_0000 / 64'd272),
    32'(64'h1_0000_0000 / 64'd342)
  };

  typedef enum logic [2:0] {
    FILL_SQUARE,
    FILL_MUL,
    FILL_RCP,
    FILL_REM,
    FILL_CORR,
    FILL_WRITE,
    FILL_DONE
  } fill_state_e;

endpackage

`default_nettype wire

[hw/rtl/ppg_ram.sv]
// Generic RAM: one write port, two registered read ports
`default_nettype none

module ppg_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 1025,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

[hw/rtl/parametric_path_point_generator_top.sv]
// Path point generator top: circle and figure-eight points from an index.
// One item per cycle while in_stall_o is low.
// A result stall holds the whole pipeline; nothing is lost or repeated.
// After reset the quarter-wave sine table is built with in_stall_o high; config writes are taken throughout.
// Reset: center 0, radius 1.0, 360 points, circle mode, pipeline empty.
`default_nettype none
`include "parametric_path_point_generator_top_defines.svh"

module parametric_path_point_generator_top import ppg_pkg::*; #(
  parameter int unsigned PHASE_BITS       = 16,
  parameter int unsigned SINE_TABLE_DEPTH = 1024,
  parameter int unsigned COORD_FRAC_BITS  = 16
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [IDX_W-1:0]      point_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [COORD_W-1:0]  point_x_o,
  output logic signed [COORD_W-1:0]  point_y_o,
  output logic                       index_error_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned DEPTH = SINE_TABLE_DEPTH;
  localparam int unsigned FULL  = 4 * DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH + 1);
  localparam int unsigned TW    = $clog2(FULL);
  localparam int unsigned FW    = $clog2(FULL + 1);
  localparam int unsigned PW    = PHASE_BITS + FW;
  localparam logic [AW-1:0] KMAX = AW'(DEPTH);
  localparam logic [63:0] ANG_STEP = HALF_PI_Q32 / 64'(FULL);
  localparam logic [63:0] ANG_FRAC = HALF_PI_Q32 % 64'(FULL);
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(64'd1 << COORD_FRAC_BITS);
  localparam logic [61:0] ROUND_HALF = 62'd1 << (Q_SHIFT - 1);
  localparam logic signed [OSUM_W-1:0] SAT_MAX = OSUM_W'(64'sd2147483647);
  localparam logic signed [OSUM_W-1:0] SAT_MIN = OSUM_W'(-64'sd2147483648);

  // ---------------------------------------------------------------- config
  logic [COORD_W-1:0]  cfg_cx_q;
  logic [COORD_W-1:0]  cfg_cy_q;
  logic [RADIUS_W-1:0] cfg_radius_q;
  logic [IDX_W-1:0]    cfg_points_q;
  logic                cfg_mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cx_q     <= '0;
      cfg_cy_q     <= '0;
      cfg_radius_q <= RADIUS_RESET;
      cfg_points_q <= IDX_W'(360);
      cfg_mode_q   <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CENTER_X:     cfg_cx_q     <= cfg_data_i[COORD_W-1:0];
        CFG_CENTER_Y:     cfg_cy_q     <= cfg_data_i[COORD_W-1:0];
        CFG_PATH_RADIUS:  cfg_radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_POINTS_COUNT: cfg_points_q <= cfg_data_i[IDX_W-1:0];
        CFG_SHAPE_MODE:   cfg_mode_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- table fill
  fill_state_e fs_q, fs_d;
  logic [AW-1:0]         fk_q;
  logic [TRIG_W-1:0]     ang_q;
  logic [TW-1:0]         arem_q;
  logic [SER_STEP_W-1:0] tn_q;
  logic [31:0]           x2_q;
  logic [TRIG_W-1:0]     term_q;
  logic [31:0]           v_q;
  logic [31:0]           q_q;
  logic [SER_REM_W-1:0]  r_q;
  logic signed [SUM_W-1:0] sum_q;

  logic                  ram_we;
  logic                  fill_done;
  logic [61:0]           sq_prod;
  logic [62:0]           mul_prod;
  logic [63:0]           rcp_prod;
  logic [31:0]           qf;
  logic [TW:0]           asum;
  logic                  acarry;
  logic [TRIG_W-1:0]     ram_wdata;

  always_comb begin
    fs_d = fs_q;
    case (fs_q)
      FILL_SQUARE: fs_d = FILL_MUL;
      FILL_MUL:    fs_d = FILL_RCP;
      FILL_RCP:    fs_d = FILL_REM;
      FILL_REM:    fs_d = FILL_CORR;
      FILL_CORR:   fs_d = (tn_q == SER_LAST) ? FILL_WRITE : FILL_MUL;
      FILL_WRITE:  fs_d = (fk_q == KMAX) ? FILL_DONE : FILL_SQUARE;
      FILL_DONE:   fs_d = FILL_DONE;
      default:     fs_d = FILL_SQUARE;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    fill_done = 1'b0;
    case (fs_q)
      FILL_WRITE: ram_we    = 1'b1;
      FILL_DONE:  fill_done = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    sq_prod  = 62'(ang_q) * 62'(ang_q);
    mul_prod = 63'(term_q) * 63'(x2_q);
    rcp_prod = 64'(v_q) * 64'(SER_RCP[tn_q]);
    qf       = q_q + 32'(r_q >= SER_DIV[tn_q]);
    asum     = (TW+1)'(arem_q) + (TW+1)'(ANG_FRAC);
    acarry   = asum >= (TW+1)'(FULL);
    if (sum_q < 0) begin
      ram_wdata = '0;
    end else if (sum_q > $signed(SUM_W'(Q30_ONE))) begin
      ram_wdata = Q30_ONE;
    end else begin
      ram_wdata = TRIG_W'(sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q   <= FILL_SQUARE;
      fk_q   <= '0;
      ang_q  <= '0;
      arem_q <= TW'(FULL / 2);
      tn_q   <= '0;
    end else begin
      fs_q <= fs_d;
      case (fs_q)
        FILL_SQUARE: tn_q <= '0;
        FILL_CORR: begin
          if (tn_q != SER_LAST) begin
            tn_q <= tn_q + SER_STEP_W'(1);
          end
        end
        FILL_WRITE: begin
          fk_q   <= fk_q + AW'(1);
          arem_q <= acarry ? TW'(asum - (TW+1)'(FULL)) : TW'(asum);
          ang_q  <= ang_q + TRIG_W'(ANG_STEP) + TRIG_W'(acarry);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (fs_q)
      FILL_SQUARE: begin
        x2_q   <= 32'(sq_prod >> Q_SHIFT);
        term_q <= ang_q;
        sum_q  <= SUM_W'(ang_q);
      end
      FILL_MUL: v_q <= 32'(mul_prod >> Q_SHIFT);
      FILL_RCP: q_q <= 32'(rcp_prod >> 32);
      FILL_REM: r_q <= SER_REM_W'(v_q - q_q * 32'(SER_DIV[tn_q]));
      FILL_CORR: begin
        term_q <= TRIG_W'(qf);
        if (tn_q[0]) begin
          sum_q <= sum_q + $signed({1'b0, qf});
        end else begin
          sum_q <= sum_q - $signed({1'b0, qf});
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- pipeline
  logic adv;
  logic in_accept;
  logic out_vld_q;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv || !fill_done;
  assign in_accept  = in_valid_i && !in_stall_o;

  // phase divider, one quotient bit per stage
  logic [IDX_W-1:0]      dv_rem_q [PHASE_BITS+1];
  logic [PHASE_BITS-1:0] dv_quo_q [PHASE_BITS+1];
  logic [PHASE_BITS:0]   dv_vld_q;
  logic [PHASE_BITS:0]   dv_err_q;
  logic [IDX_W:0]        dv_sh    [PHASE_BITS];
  logic [PHASE_BITS-1:0] dv_ge;
  logic [IDX_W-1:0]      dv_rem_d [PHASE_BITS];
  logic [PHASE_BITS-1:0] dv_quo_d [PHASE_BITS];

  always_comb begin
    for (int j = 0; j < PHASE_BITS; j++) begin
      dv_sh[j]    = {dv_rem_q[j], 1'b0};
      dv_ge[j]    = dv_sh[j] >= {1'b0, cfg_points_q};
      dv_rem_d[j] = dv_ge[j] ? IDX_W'(dv_sh[j] - {1'b0, cfg_points_q})
                             : dv_sh[j][IDX_W-1:0];
      dv_quo_d[j] = {dv_quo_q[j][PHASE_BITS-2:0], dv_ge[j]};
    end
  end

  // phase to table position
  logic [PW-1:0] t_prod;
  logic [FW-1:0] t_raw;
  logic [TW-1:0] t_d, t_q;
  logic          t_vld_q, t_err_q;

  always_comb begin
    t_prod = PW'(dv_quo_q[PHASE_BITS]) * PW'(FULL) + (PW'(1) << (PHASE_BITS - 1));
    t_raw  = FW'(t_prod >> PHASE_BITS);
    t_d    = (t_raw >= FW'(FULL)) ? TW'(t_raw - FW'(FULL)) : TW'(t_raw);
  end

  // quadrant and offset
  logic [1:0]    a_quad_d, a_quad_q;
  logic [TW-1:0] a_kt;
  logic [AW-1:0] a_k_q;
  logic          a_vld_q, a_err_q;

  always_comb begin
    if (t_q >= TW'(3 * DEPTH)) begin
      a_quad_d = 2'd3;
      a_kt     = t_q - TW'(3 * DEPTH);
    end else if (t_q >= TW'(2 * DEPTH)) begin
      a_quad_d = 2'd2;
      a_kt     = t_q - TW'(2 * DEPTH);
    end else if (t_q >= TW'(DEPTH)) begin
      a_quad_d = 2'd1;
      a_kt     = t_q - TW'(DEPTH);
    end else begin
      a_quad_d = 2'd0;
      a_kt     = t_q;
    end
  end

  // table read
  logic [TRIG_W-1:0] ram_rd_a, ram_rd_b;
  logic [1:0]        b_quad_q;
  logic              b_vld_q, b_err_q;

  ppg_ram #(
    .WIDTH(TRIG_W),
    .DEPTH(DEPTH + 1)
  ) u_table (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (fk_q),
    .wdata_i  (ram_wdata),
    .re_i     (adv),
    .raddr_a_i(a_k_q),
    .raddr_b_i(KMAX - a_k_q),
    .rdata_a_o(ram_rd_a),
    .rdata_b_o(ram_rd_b)
  );

  // sine and cosine, figure-eight product
  logic [TRIG_W-1:0] c_smag, c_cmag;
  logic              c_sneg, c_cneg;
  logic [61:0]       c_prod;
  logic [TRIG_W-1:0] c_sc;
  logic [TRIG_W-1:0] c_xm_q, c_ym_q;
  logic              c_xn_q, c_yn_q;
  logic              c_vld_q, c_err_q;

  always_comb begin
    case (b_quad_q)
      2'd0: begin
        c_smag = ram_rd_a; c_sneg = 1'b0; c_cmag = ram_rd_b; c_cneg = 1'b0;
      end
      2'd1: begin
        c_smag = ram_rd_b; c_sneg = 1'b0; c_cmag = ram_rd_a; c_cneg = 1'b1;
      end
      2'd2: begin
        c_smag = ram_rd_a; c_sneg = 1'b1; c_cmag = ram_rd_b; c_cneg = 1'b1;
      end
      default: begin
        c_smag = ram_rd_b; c_sneg = 1'b1; c_cmag = ram_rd_a; c_cneg = 1'b0;
      end
    endcase
    c_prod = 62'(c_smag) * 62'(c_cmag) + ROUND_HALF;
    c_sc   = TRIG_W'(c_prod >> Q_SHIFT);
  end

  // radius scaling
  logic [61:0]      d_xprod, d_yprod;
  logic [MAG_W-1:0] d_xm_q, d_ym_q;
  logic             d_xn_q, d_yn_q;
  logic             d_vld_q, d_err_q;

  always_comb begin
    d_xprod = 62'(cfg_radius_q) * 62'(c_xm_q) + ROUND_HALF;
    d_yprod = 62'(cfg_radius_q) * 62'(c_ym_q) + ROUND_HALF;
  end

  // center offset and saturation
  logic signed [OSUM_W-1:0] e_xsum, e_ysum;
  logic [COORD_W-1:0]       e_x, e_y;
  logic [COORD_W-1:0]       point_x_q, point_y_q;
  logic                     index_error_q;

  always_comb begin
    e_xsum = $signed({{2{cfg_cx_q[COORD_W-1]}}, cfg_cx_q})
           + (d_xn_q ? -$signed({2'b00, d_xm_q}) : $signed({2'b00, d_xm_q}));
    e_ysum = $signed({{2{cfg_cy_q[COORD_W-1]}}, cfg_cy_q})
           + (d_yn_q ? -$signed({2'b00, d_ym_q}) : $signed({2'b00, d_ym_q}));
    if (d_err_q) begin
      e_x = '0;
    end else if (e_xsum > SAT_MAX) begin
      e_x = COORD_W'(SAT_MAX);
    end else if (e_xsum < SAT_MIN) begin
      e_x = COORD_W'(SAT_MIN);
    end else begin
      e_x = COORD_W'(e_xsum);
    end
    if (d_err_q) begin
      e_y = '0;
    end else if (e_ysum > SAT_MAX) begin
      e_y = COORD_W'(SAT_MAX);
    end else if (e_ysum < SAT_MIN) begin
      e_y = COORD_W'(SAT_MIN);
    end else begin
      e_y = COORD_W'(e_ysum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q  <= '0;
      t_vld_q   <= 1'b0;
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      dv_vld_q  <= {dv_vld_q[PHASE_BITS-1:0], in_accept};
      t_vld_q   <= dv_vld_q[PHASE_BITS];
      a_vld_q   <= t_vld_q;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      out_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_rem_q[0] <= point_index_i;
      dv_quo_q[0] <= '0;
      dv_err_q    <= {dv_err_q[PHASE_BITS-1:0], point_index_i >= cfg_points_q};
      for (int j = 0; j < PHASE_BITS; j++) begin
        dv_rem_q[j+1] <= dv_rem_d[j];
        dv_quo_q[j+1] <= dv_quo_d[j];
      end

      t_q     <= t_d;
      t_err_q <= dv_err_q[PHASE_BITS];

      a_quad_q <= a_quad_d;
      a_k_q    <= AW'(a_kt);
      a_err_q  <= t_err_q;

      b_quad_q <= a_quad_q;
      b_err_q  <= a_err_q;

      c_xm_q  <= c_cmag;
      c_xn_q  <= c_cneg;
      c_ym_q  <= cfg_mode_q ? c_sc : c_smag;
      c_yn_q  <= cfg_mode_q ? (c_sneg ^ c_cneg) : c_sneg;
      c_err_q <= b_err_q;

      d_xm_q  <= MAG_W'(d_xprod >> Q_SHIFT);
      d_ym_q  <= MAG_W'(d_yprod >> Q_SHIFT);
      d_xn_q  <= c_xn_q;
      d_yn_q  <= c_yn_q;
      d_err_q <= c_err_q;

      point_x_q     <= e_x;
      point_y_q     <= e_y;
      index_error_q <= d_err_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign point_x_o     = point_x_q;
  assign point_y_o     = point_y_q;
  assign index_error_o = index_error_q;

  // ---------------------------------------------------------------- checks
  `PPG_ASSERT_IMPL(a_err_zero, out_valid_o && index_error_o, point_x_o == '0 && point_y_o == '0, "error item with nonzero coordinates")
  `PPG_ASSERT_IMPL(a_no_out_in_fill, !fill_done, !out_valid_o, "result presented while table fill runs")
  `PPG_ASSERT_IMPL(a_fill_last, $rose(fill_done), $past(fk_q) == KMAX, "table fill ended before last entry")
  `PPG_ASSERT_NEXT(a_write_advance, ram_we && fk_q != KMAX, fk_q == $past(fk_q) + AW'(1), "fill address did not advance")

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench of the path point generator: predicts each point and checks results
`timescale 1ns / 100ps

module tb_top;
  import ppg_pkg::*;

  localparam int unsigned PHASE_BITS      = 16;
  localparam int unsigned SINE_DEPTH      = 1024;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned FULL_TURN       = 4 * SINE_DEPTH;
  localparam int unsigned DRAIN_CYCLES    = 40;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned WATCHDOG_LIMIT  = 200000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS     = 85;
  localparam int unsigned REPORT_LINES    = 40;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_SHAPE_MODE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               err;
  } point_t;

  class path_point_board;
    longint             sine_tab [0:SINE_DEPTH];
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [RADIUS_W-1:0] radius;
    logic [IDX_W-1:0]   n_points;
    logic               figure8;
    point_t             expected_points [$];
    int                 mismatches;

    function new();
      u64_t ang;
      for (int k = 0; k <= SINE_DEPTH; k++) begin
        ang = (u64_t'(k) * HALF_PI_Q32 + u64_t'(FULL_TURN / 2)) / u64_t'(FULL_TURN);
        sine_tab[k] = sine_series(ang);
      end
      cx = '0;
      cy = '0;
      radius = RADIUS_W'(1) << COORD_FRAC_BITS;
      n_points = 16'd360;
      figure8 = 1'b0;
      mismatches = 0;
    endfunction

    function longint sine_series(u64_t x);
      u64_t   x2;
      u64_t   term;
      longint acc;
      x2 = (x * x) >> 30;
      term = x;
      acc = longint'(x);
      for (int n = 1; n < 10; n++) begin
        term = ((term * x2) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc -= longint'(term);
        else acc += longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (longint'(1) << 30)) acc = longint'(1) << 30;
      return acc;
    endfunction

    function longint scale_q30(u64_t mag, longint v);
      u64_t av;
      u64_t p;
      av = (v < 0) ? u64_t'(-v) : u64_t'(v);
      p = (mag * av + (u64_t'(1) << 29)) >> 30;
      return (v < 0) ? -longint'(p) : longint'(p);
    endfunction

    function logic [COORD_W-1:0] sat32(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return 32'h7FFF_FFFF;
      if (v < -longint'(64'h8000_0000)) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_CENTER_X:     cx = data;
        CFG_CENTER_Y:     cy = data;
        CFG_PATH_RADIUS:  radius = data[RADIUS_W-1:0];
        CFG_POINTS_COUNT: n_points = data[IDX_W-1:0];
        CFG_SHAPE_MODE:   figure8 = data[0];
        default: ;
      endcase
    endfunction

    function point_t predict_point(logic [IDX_W-1:0] idx);
      point_t pt;
      u64_t   phase;
      u64_t   t;
      u64_t   k;
      int     quad;
      longint s;
      longint c;
      longint sc;
      longint dy;
      pt.x = '0;
      pt.y = '0;
      pt.err = 1'b1;
      if (n_points == 0 || idx >= n_points) return pt;
      phase = (u64_t'(idx) << PHASE_BITS) / u64_t'(n_points);
      t = (phase * FULL_TURN + (u64_t'(1) << (PHASE_BITS - 1))) >> PHASE_BITS;
      if (t >= FULL_TURN) t -= FULL_TURN;
      quad = int'(t / SINE_DEPTH);
      k = t % SINE_DEPTH;
      case (quad)
        0: begin
          s = sine_tab[k];
          c = sine_tab[SINE_DEPTH - k];
        end
        1: begin
          s = sine_tab[SINE_DEPTH - k];
          c = -sine_tab[k];
        end
        2: begin
          s = -sine_tab[k];
          c = -sine_tab[SINE_DEPTH - k];
        end
        default: begin
          s = -sine_tab[SINE_DEPTH - k];
          c = sine_tab[k];
        end
      endcase
      if (figure8) begin
        sc = scale_q30(u64_t'((s < 0) ? -s : s), c);
        if (s < 0) sc = -sc;
        dy = scale_q30(u64_t'(radius), sc);
      end else begin
        dy = scale_q30(u64_t'(radius), s);
      end
      pt.x = sat32(longint'($signed(cx)) + scale_q30(u64_t'(radius), c));
      pt.y = sat32(longint'($signed(cy)) + dy);
      pt.err = 1'b0;
      return pt;
    endfunction

    function void note_index(logic [IDX_W-1:0] idx);
      expected_points.push_back(predict_point(idx));
    endfunction

    function int pending_count();
      return expected_points.size();
    endfunction

    task report_mismatch(string what, logic [COORD_W-1:0] got, logic [COORD_W-1:0] want);
      mismatches++;
      if (mismatches <= REPORT_LINES)
        $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    task check_point(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y, logic err);
      point_t want;
      if (expected_points.size() == 0) begin
        report_mismatch("result with no pending item", x, '0);
      end else begin
        want = expected_points.pop_front();
        if (x !== want.x) report_mismatch("point_x", x, want.x);
        if (y !== want.y) report_mismatch("point_y", y, want.y);
        if (err !== want.err) report_mismatch("index_error", COORD_W'(err), COORD_W'(want.err));
      end
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [IDX_W-1:0]      point_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [COORD_W-1:0] point_x_o;
  logic signed [COORD_W-1:0] point_y_o;
  logic                  index_error_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  path_point_board board = new();
  bit  hold_req = 1'b0;
  int  burst_left = 0;
  int  idle_cycles = 0;

  parametric_path_point_generator_top #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_DEPTH(SINE_DEPTH),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .point_index_i(point_index_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .index_error_o(index_error_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("parametric_path_point_generator_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int  style;
    int  style_left;
    int  hold_left;
    bit  stall_next;
    style = 0;
    style_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i)
        board.check_point(point_x_o, point_y_o, index_error_o);
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        stall_next = 1'b1;
      end else begin
        if (style_left == 0) begin
          style = $urandom_range(0, 3);
          style_left = $urandom_range(16, 128);
        end
        style_left--;
        case (style)
          0: stall_next = 1'b0;
          1: stall_next = ($urandom_range(0, 4) == 0);
          2: stall_next = ($urandom_range(0, 3) != 0);
          default: stall_next = style_left[0];
        endcase
      end
      out_stall_i <= stall_next;
    end
  end

  task automatic send_index(input logic [IDX_W-1:0] idx);
    int gap;
    in_valid_i <= 1'b1;
    point_index_i <= idx;
    do @(posedge clk_i); while (in_stall_o);
    board.note_index(idx);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (board.pending_count() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                              input logic [CFG_DATA_W-1:0] r, input logic [CFG_DATA_W-1:0] n,
                              input logic [CFG_DATA_W-1:0] mode, input bit spare);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_PATH_RADIUS, r);
    write_reg(CFG_POINTS_COUNT, n);
    write_reg(CFG_SHAPE_MODE, mode);
    if (spare)
      write_reg(CFG_IDX_W'($urandom_range(CFG_SPARE_HI, CFG_SPARE_LO)), $urandom);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_center();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: v = $urandom;
      default: begin
        v = $urandom & 32'h01FF_FFFF;
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_radius();
    case ($urandom_range(0, 3))
      0: return 32'hFFFF_FFFF;
      1: return $urandom;
      default: return $urandom_range(0, 1 << 23) | ($urandom & 32'h8000_0000);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_count();
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 15))
      0: v = 0;
      1, 2, 3, 4: v = $urandom_range(1, 16);
      5: v = 32'h0000_FFFF;
      default: v = $urandom_range(1, 65535);
    endcase
    return v | ($urandom & 32'hFFFF_0000);
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    int n;
    n = int'(board.n_points);
    if (n == 0) return IDX_W'($urandom);
    case ($urandom_range(0, 19))
      0, 1: return IDX_W'($urandom);
      2: return IDX_W'(n - 1);
      3: return IDX_W'(n);
      default: return IDX_W'($urandom_range(0, n - 1));
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_index(16'd0);
    send_index(16'd90);
    send_index(16'd180);
    send_index(16'd270);
    send_index(16'd359);
    send_index(16'd360);
    send_index(16'hFFFF);
    wait_drained();

    write_config(32'h7FFF_FFFF, 32'h7FFF_FF00, 32'hFFFF_FFFF, 32'h0000_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_index(16'd0);
    send_index(16'd16384);
    send_index(16'd32767);
    send_index(16'd49152);
    send_index(16'd65534);
    wait_drained();

    write_config(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hABCD_0004, 32'h0000_0002,
                 1'b1);
    for (int i = 0; i <= 4; i++) send_index(IDX_W'(i));
    wait_drained();

    write_config(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0001, 32'h0000_0001,
                 1'b0);
    send_index(16'd0);
    send_index(16'd1);
    wait_drained();

    write_config(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                 1'b0);
    send_index(16'd0);
    send_index(16'hFFFF);
    send_index(16'd12345);
    wait_drained();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_config(pick_center(), pick_center(), pick_radius(), pick_count(), $urandom,
                   $urandom_range(0, 2) == 0);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((p == 2 || p == 5) && i == 5) hold_req = 1'b1;
        send_index(pick_index());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending_count() == 0) begin
      $display("parametric_path_point_generator_top verification clean");
    end else begin
      $display("parametric_path_point_generator_top verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ppg_pkg.sv
hw/rtl/ppg_ram.sv
hw/rtl/parametric_path_point_generator_top.sv
tb/tb_top.sv
